// ----- rtl/eci_pkg.sv -----
// Package for the easing curve interpolator: table sizes, style codes and
// the constant sine and power-of-two tables built at elaboration.
// No dependencies.
package eci_pkg;

  localparam int SINE_TABLE_ENTRIES = 256;
  localparam int EXP_TABLE_ENTRIES  = 256;

  // index widths hold 0..ENTRIES; position words hold q * ENTRIES
  localparam int SIW = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int EIW = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int SPW = 17 + SIW;
  localparam int EPW = 17 + EIW;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  // table build constants: entry count, its rounding half and one in Q30
  localparam logic [63:0] SINE_N64    = 64'(SINE_TABLE_ENTRIES);
  localparam logic [63:0] EXP_N64     = 64'(EXP_TABLE_ENTRIES);
  localparam logic [63:0] SINE_HALF_N = 64'(SINE_TABLE_ENTRIES / 2);
  localparam logic [63:0] EXP_HALF_N  = 64'(EXP_TABLE_ENTRIES / 2);
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef enum logic [3:0] {
    STYLE_LINEAR = 4'd0,
    SINE_IN      = 4'd1,
    SINE_OUT     = 4'd2,
    SINE_INOUT   = 4'd3,
    CUBIC_IN     = 4'd4,
    CUBIC_OUT    = 4'd5,
    CUBIC_INOUT  = 4'd6,
    EXPO_IN      = 4'd7,
    EXPO_OUT     = 4'd8,
    EXPO_INOUT   = 4'd9
  } ease_style_t;

  typedef logic [SINE_TABLE_ENTRIES:0][16:0] sine_rom_t;
  typedef logic [EXP_TABLE_ENTRIES:0][17:0]  exp_rom_t;

  // quarter-wave sine in Q16, series evaluated in Q30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      x  = (64'd1686629713 * 64'(k) + SINE_HALF_N) / SINE_N64;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
      s = (((x * t) >> 30) + 64'd8192) >> 14;
      if (s > 64'd65536) s = 64'd65536;
      rom[k] = s[16:0];
    end
    rom[SINE_TABLE_ENTRIES] = ONE_Q16;
    return rom;
  endfunction

  // 2^(k/N) in Q16 over one octave, ends pinned to one and two
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] z;
    logic [63:0] t;
    logic [63:0] s;
    for (int k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
      z = (64'd744261118 * 64'(k) + EXP_HALF_N) / EXP_N64;
      t = ONE_Q30;
      t = ONE_Q30 + (((z * t) >> 30) / 64'd10);
      t = ONE_Q30 + (((z * t) >> 30) / 64'd9);
      t = ONE_Q30 + (((z * t) >> 30) / 64'd8);
      t = ONE_Q30 + (((z * t) >> 30) / 64'd7);
      t = ONE_Q30 + (((z * t) >> 30) / 64'd6);
      t = ONE_Q30 + (((z * t) >> 30) / 64'd5);
      t = ONE_Q30 + (((z * t) >> 30) / 64'd4);
      t = ONE_Q30 + (((z * t) >> 30) / 64'd3);
      t = ONE_Q30 + (((z * t) >> 30) >> 1);
      t = ONE_Q30 + ((z * t) >> 30);
      s = (t + 64'd8192) >> 14;
      rom[k] = s[17:0];
    end
    rom[0] = 18'd65536;
    rom[EXP_TABLE_ENTRIES] = 18'd131072;
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();
  localparam exp_rom_t  EXP_ROM  = build_exp_rom();

endpackage

// ----- rtl/eci_if.sv -----
// Valid/ready channel interfaces for the easing curve interpolator.
// Depends on nothing; payload widths follow the item fields.
interface eci_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_value;
  logic signed [31:0] goal_value;
  logic signed [31:0] current_value;
  logic        [16:0] progress;
  logic        [3:0]  ease_style;

  modport source (output valid, start_value, goal_value, current_value, progress,
                  ease_style, input ready);
  modport sink (input valid, start_value, goal_value, current_value, progress,
                ease_style, output ready);
endinterface

interface eci_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eased_value;

  modport source (output valid, eased_value, input ready);
  modport sink (input valid, eased_value, output ready);
endinterface

// ----- rtl/eci_shape.sv -----
// Eased weight pipeline: four register stages from clamped fraction and style
// to the Q1.16 weight. Uses eci_pkg for style codes and tables.
module eci_shape (
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] f,
  input  logic [3:0]  style,
  output logic [16:0] e
);

  // stage A: table arguments and cube base
  logic [16:0] p_nxt, x_nxt;
  logic [20:0] a_nxt;
  logic        hi_nxt;
  logic [17:0] f2;
  logic [20:0] f10;
  logic [21:0] f20;

  logic [16:0] p_r, x_r, fa_r;
  logic [19:0] a_r;
  logic        hia_r;
  logic [3:0]  sta_r;

  always_comb begin
    f2     = {f, 1'b0};
    f10    = 21'(f) * 21'd10;
    f20    = 22'(f) * 22'd20;
    p_nxt  = f;
    x_nxt  = f;
    a_nxt  = '0;
    hi_nxt = 1'b0;
    unique case (style)
      eci_pkg::SINE_IN:  p_nxt = eci_pkg::ONE_Q16 - f;
      eci_pkg::SINE_OUT: p_nxt = f;
      eci_pkg::SINE_INOUT: begin
        hi_nxt = (f > eci_pkg::HALF_Q16);
        p_nxt  = hi_nxt ? 17'(f2 - 18'(eci_pkg::ONE_Q16))
                        : 17'(18'(eci_pkg::ONE_Q16) - f2);
      end
      eci_pkg::CUBIC_IN:  x_nxt = f;
      eci_pkg::CUBIC_OUT: x_nxt = eci_pkg::ONE_Q16 - f;
      eci_pkg::CUBIC_INOUT: begin
        hi_nxt = (f >= eci_pkg::HALF_Q16);
        x_nxt  = hi_nxt ? 17'(18'd131072 - f2) : f;
      end
      eci_pkg::EXPO_IN:  a_nxt = 21'd655360 - f10;
      eci_pkg::EXPO_OUT: a_nxt = f10;
      eci_pkg::EXPO_INOUT: begin
        hi_nxt = (f >= eci_pkg::HALF_Q16);
        a_nxt  = hi_nxt ? 21'(f20 - 22'd655360) : 21'(22'd655360 - f20);
      end
      default: p_nxt = f;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= p_nxt;
      x_r   <= x_nxt;
      a_r   <= a_nxt[19:0];
      hia_r <= hi_nxt;
      sta_r <= style;
      fa_r  <= f;
    end
  end

  // stage B: table reads and square
  logic [eci_pkg::SPW-1:0] spos;
  logic [eci_pkg::EPW-1:0] epos;
  logic [eci_pkg::SIW-1:0] si, si1;
  logic [eci_pkg::EIW-1:0] ei, ei1;
  logic [16:0]             q;
  logic [16:0]             st0, st1;
  logic [17:0]             et0, et1;

  logic [16:0] st0_r, sdiff_r, xb_r, fb_r;
  logic [15:0] sfr_r, efr_r;
  logic [17:0] et0_r, ediff_r;
  logic [3:0]  nb_r, stb_r;
  logic [33:0] xx_r;
  logic        hib_r;

  always_comb begin
    spos = eci_pkg::SPW'(p_r) * eci_pkg::SPW'(eci_pkg::SINE_TABLE_ENTRIES);
    si   = spos[16 +: eci_pkg::SIW];
    si1  = (si == eci_pkg::SIW'(eci_pkg::SINE_TABLE_ENTRIES)) ? si
                                                               : eci_pkg::SIW'(si + 1'b1);
    st0  = eci_pkg::SINE_ROM[si];
    st1  = eci_pkg::SINE_ROM[si1];
    q    = eci_pkg::ONE_Q16 - {1'b0, a_r[15:0]};
    epos = eci_pkg::EPW'(q) * eci_pkg::EPW'(eci_pkg::EXP_TABLE_ENTRIES);
    ei   = epos[16 +: eci_pkg::EIW];
    ei1  = (ei == eci_pkg::EIW'(eci_pkg::EXP_TABLE_ENTRIES)) ? ei
                                                              : eci_pkg::EIW'(ei + 1'b1);
    et0  = eci_pkg::EXP_ROM[ei];
    et1  = eci_pkg::EXP_ROM[ei1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st0_r   <= st0;
      sdiff_r <= st1 - st0;
      sfr_r   <= spos[15:0];
      et0_r   <= et0;
      ediff_r <= et1 - et0;
      efr_r   <= epos[15:0];
      nb_r    <= a_r[19:16];
      xx_r    <= 34'(x_r) * 34'(x_r);
      xb_r    <= x_r;
      hib_r   <= hia_r;
      stb_r   <= sta_r;
      fb_r    <= fa_r;
    end
  end

  // stage C: interpolation products and cube
  logic [32:0] sprod_r;
  logic [33:0] eprod_r;
  logic [50:0] cube_r;
  logic [16:0] st0c_r, fc_r;
  logic [17:0] et0c_r;
  logic [3:0]  nc_r, stc_r;
  logic        hic_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sprod_r <= 33'(sdiff_r) * 33'(sfr_r);
      eprod_r <= 34'(ediff_r) * 34'(efr_r);
      cube_r  <= 51'(xx_r) * 51'(xb_r);
      st0c_r  <= st0_r;
      et0c_r  <= et0_r;
      nc_r    <= nb_r;
      hic_r   <= hib_r;
      stc_r   <= stb_r;
      fc_r    <= fb_r;
    end
  end

  // stage D: round, shift and fold into the weight
  logic [33:0] sr, er;
  logic [16:0] s;
  logic [17:0] m;
  logic [18:0] msum;
  logic [4:0]  sh;
  logic [16:0] v;
  logic [51:0] c52;
  logic [16:0] c32, c30, c33;
  logic [17:0] sum_s, sum_v;
  logic [16:0] e_nxt;
  logic [16:0] e_r;

  always_comb begin
    sr    = 34'(sprod_r) + 34'd32768;
    er    = eprod_r + 34'd32768;
    s     = 17'(st0c_r + sr[32:16]);
    m     = 18'(et0c_r + er[33:16]);
    sh    = {1'b0, nc_r} + 5'd1;
    msum  = 19'(m) + (19'd1 << nc_r);
    v     = 17'(msum >> sh);
    c52   = 52'(cube_r);
    c32   = 17'((c52 + 52'h0_8000_0000) >> 32);
    c30   = 17'((c52 + 52'h0_2000_0000) >> 30);
    c33   = 17'((c52 + 52'h1_0000_0000) >> 33);
    sum_s = 18'd0;
    sum_v = 18'd0;
    e_nxt = fc_r;
    unique case (stc_r)
      eci_pkg::SINE_IN:  e_nxt = eci_pkg::ONE_Q16 - s;
      eci_pkg::SINE_OUT: e_nxt = s;
      eci_pkg::SINE_INOUT: begin
        sum_s = hic_r ? (18'(eci_pkg::ONE_Q16) + 18'(s) + 18'd1)
                      : (18'(eci_pkg::ONE_Q16) - 18'(s) + 18'd1);
        e_nxt = sum_s[17:1];
      end
      eci_pkg::CUBIC_IN:    e_nxt = c32;
      eci_pkg::CUBIC_OUT:   e_nxt = eci_pkg::ONE_Q16 - c32;
      eci_pkg::CUBIC_INOUT: e_nxt = hic_r ? (eci_pkg::ONE_Q16 - c33) : c30;
      eci_pkg::EXPO_IN:     e_nxt = (fc_r == '0) ? '0 : v;
      eci_pkg::EXPO_OUT: begin
        e_nxt = (fc_r == eci_pkg::ONE_Q16) ? eci_pkg::ONE_Q16 : (eci_pkg::ONE_Q16 - v);
      end
      eci_pkg::EXPO_INOUT: begin
        sum_v = hic_r ? (18'd131072 - 18'(v) + 18'd1) : (18'(v) + 18'd1);
        priority if (fc_r == '0) begin
          e_nxt = '0;
        end else if (fc_r == eci_pkg::ONE_Q16) begin
          e_nxt = eci_pkg::ONE_Q16;
        end else begin
          e_nxt = sum_v[17:1];
        end
      end
      default: e_nxt = fc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r <= e_nxt;
    end
  end

  assign e = e_r;

endmodule

// ----- rtl/easing_curve_interpolator_core.sv -----
// Easing curve interpolator: one Penner easing evaluation per transfer,
// start + (goal - start) * eased(progress), Q16.16, saturated. Depends on
// eci_pkg, eci_if and eci_shape. A new item is taken every cycle unless the
// output stalls; each result passes the input register, four weight stages,
// the final multiply and the output register. The goal passes through when
// current equals goal. The whole pipeline holds while a result waits at the output, so a stalled sink pauses intake.
module easing_curve_interpolator_core (
  input logic       clk,
  input logic       rst_n,
  eci_in_if.sink    in_ch,
  eci_out_if.source out_ch
);

  typedef struct packed {
    logic signed [32:0] diff;
    logic signed [31:0] start;
    logic signed [31:0] goal;
    logic               eq;
  } side_t;

  logic        adv;
  logic [5:0]  vld_r;
  logic        out_valid_r;
  logic [16:0] f_clamp;
  logic [16:0] f1_r;
  logic [3:0]  style1_r;
  side_t       side_nxt;
  side_t       side_r [5];
  side_t       pside_r;
  logic [16:0] e_w;
  logic signed [50:0] prod_r;
  logic signed [50:0] rnd;
  logic signed [51:0] sum;
  logic signed [31:0] sat;
  logic signed [31:0] out_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    f_clamp        = (in_ch.progress > eci_pkg::ONE_Q16) ? eci_pkg::ONE_Q16 : in_ch.progress;
    side_nxt.diff  = 33'(in_ch.goal_value) - 33'(in_ch.start_value);
    side_nxt.start = in_ch.start_value;
    side_nxt.goal  = in_ch.goal_value;
    side_nxt.eq    = (in_ch.current_value == in_ch.goal_value);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[4:0], in_ch.valid};
      out_valid_r <= vld_r[5];
    end
  end

  // payload advances with the valid bits
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r      <= f_clamp;
      style1_r  <= in_ch.ease_style;
      side_r[0] <= side_nxt;
      for (int i = 1; i < 5; i++) begin
        side_r[i] <= side_r[i-1];
      end
      prod_r  <= 51'(side_r[4].diff) * 51'(signed'({1'b0, e_w}));
      pside_r <= side_r[4];
      out_r   <= pside_r.eq ? pside_r.goal : sat;
    end
  end

  eci_shape u_shape (
    .clk   (clk),
    .en    (adv),
    .f     (f1_r),
    .style (style1_r),
    .e     (e_w)
  );

  // round half up, add start, clamp to 32 bits
  always_comb begin
    rnd = (prod_r + 51'sd32768) >>> 16;
    sum = 52'(pside_r.start) + 52'(rnd);
    priority if (sum > 52'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (sum < -52'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.eased_value = out_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && out_ch.valid)
    else $error("pipeline valid bits moved during a stall");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> e_w <= eci_pkg::ONE_Q16)
    else $error("eased weight above one");

  a_goal_pass: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[5] && pside_r.eq |=> out_ch.eased_value == $past(pside_r.goal))
    else $error("goal not passed through when current equals goal");

endmodule
